@@ design/dual_valve_drive_supervisor_assert.svh @@
// assertion macros for the dual valve drive supervisor
`ifndef DUAL_VALVE_DRIVE_SUPERVISOR_ASSERT_SVH
`define DUAL_VALVE_DRIVE_SUPERVISOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define DVDS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dvds assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DVDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dvds assertion failed");

`endif

@@ design/dvds_pkg.sv @@
// shared types and constants of the dual valve drive supervisor
package dvds_pkg;

	localparam int CFG_W                = 16;
	localparam int TICK_COUNT_WIDTH_DEF = 16;

	localparam logic [CFG_W-1:0] CURRENT_CHECK_RESET = 16'd100;
	localparam logic [CFG_W-1:0] RUN_LIMIT_RESET     = 16'd15000;
	localparam logic             COLD_LEVEL_RESET    = 1'b1;
	localparam logic             HOT_LEVEL_RESET     = 1'b0;

	typedef enum logic [2:0] {
		ACT_TICK     = 3'd0,
		ACT_KEY      = 3'd1,
		ACT_OPEN     = 3'd2,
		ACT_CLOSE    = 3'd3,
		ACT_STOP     = 3'd4,
		ACT_FINISH   = 3'd5,
		ACT_OVERLOAD = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		CFG_CURRENT_CHECK = 2'd0,
		CFG_RUN_LIMIT     = 2'd1,
		CFG_COLD_LEVEL    = 2'd2,
		CFG_HOT_LEVEL     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		FAULT_OK       = 2'd0,
		FAULT_OVERLOAD = 2'd1,
		FAULT_NO_POWER = 2'd2,
		FAULT_TIMEOUT  = 2'd3
	} fault_t;

	typedef enum logic [1:0] {
		LAMP_OFF   = 2'd0,
		LAMP_ON    = 2'd1,
		LAMP_BLINK = 2'd2
	} lamp_t;

	typedef enum logic [1:0] {
		POS_UNDEF  = 2'd0,
		POS_CLOSED = 2'd1,
		POS_OPEN   = 2'd2
	} pos_t;

	typedef struct packed {
		action_t action;
		logic    sel;
		logic    check;
		logic    open_pin;
		logic    closed_pin;
		logic    current;
		logic    open_level;
	} valve_in_t;

	typedef struct packed {
		logic   enable;
		logic   direction;
		fault_t fault;
		lamp_t  open_lamp;
		lamp_t  closed_lamp;
	} valve_out_t;

	function automatic pos_t decode_pos(input logic open_pin, input logic closed_pin);
		pos_t p;
		if (!open_pin && closed_pin)
			p = POS_OPEN;
		else if (open_pin && !closed_pin)
			p = POS_CLOSED;
		else
			p = POS_UNDEF;
		return p;
	endfunction

endpackage

@@ design/dvds_valve.sv @@
// per-valve drive state, timers and lamp logic
module dvds_valve
	import dvds_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  valve_in_t        req,
	input  logic [CFG_W-1:0] current_check_ticks,
	input  logic [CFG_W-1:0] run_limit_ticks,
	output valve_out_t       nxt
);

	localparam int TW = TICK_COUNT_WIDTH;

	logic          on_q, dir_q, cc_arm_q, rl_arm_q;
	fault_t        fault_q;
	lamp_t         open_lamp_q, closed_lamp_q;
	logic [TW-1:0] cc_cnt_q, rl_cnt_q;

	logic          on_n, dir_n, cc_arm_n, rl_arm_n;
	fault_t        fault_n;
	lamp_t         open_lamp_n, closed_lamp_n;
	logic [TW-1:0] cc_cnt_n, rl_cnt_n;

	logic          do_start, start_open;
	pos_t          pos;

	assign pos = decode_pos(req.open_pin, req.closed_pin);

	always_comb begin
		on_n          = on_q;
		dir_n         = dir_q;
		fault_n       = fault_q;
		cc_arm_n      = cc_arm_q;
		cc_cnt_n      = cc_cnt_q;
		rl_arm_n      = rl_arm_q;
		rl_cnt_n      = rl_cnt_q;
		open_lamp_n   = open_lamp_q;
		closed_lamp_n = closed_lamp_q;
		do_start      = 1'b0;
		start_open    = 1'b0;

		case (req.action)
			ACT_TICK: begin
				if (cc_arm_q) begin
					if (cc_cnt_q <= TW'(1)) begin
						cc_cnt_n = '0;
						cc_arm_n = 1'b0;
						if (!req.current) begin
							rl_arm_n = 1'b0;
							rl_cnt_n = '0;
							if (fault_q == FAULT_OK) begin
								on_n  = 1'b0;
								dir_n = 1'b0;
							end
							fault_n       = FAULT_NO_POWER;
							open_lamp_n   = LAMP_BLINK;
							closed_lamp_n = LAMP_BLINK;
						end
					end else begin
						cc_cnt_n = cc_cnt_q - TW'(1);
					end
				end
				if (rl_arm_n) begin
					if (rl_cnt_n <= TW'(1)) begin
						rl_cnt_n = '0;
						rl_arm_n = 1'b0;
						if (on_n) begin
							if (fault_n == FAULT_OK) begin
								on_n  = 1'b0;
								dir_n = 1'b0;
							end
							fault_n       = FAULT_TIMEOUT;
							open_lamp_n   = LAMP_BLINK;
							closed_lamp_n = LAMP_BLINK;
						end
					end else begin
						rl_cnt_n = rl_cnt_n - TW'(1);
					end
				end
			end
			ACT_KEY: begin
				if (req.sel) begin
					fault_n = FAULT_OK;
					if (!on_q) begin
						open_lamp_n   = LAMP_OFF;
						closed_lamp_n = LAMP_OFF;
					end
					do_start   = 1'b1;
					start_open = (pos == POS_CLOSED);
				end
			end
			ACT_OPEN: begin
				if (req.sel && (!req.check || pos == POS_CLOSED)) begin
					do_start   = 1'b1;
					start_open = 1'b1;
				end
			end
			ACT_CLOSE: begin
				if (req.sel && (!req.check || pos == POS_OPEN))
					do_start = 1'b1;
			end
			ACT_STOP: begin
				if (req.sel) begin
					if (fault_q == FAULT_OK) begin
						on_n  = 1'b0;
						dir_n = 1'b0;
					end
					open_lamp_n   = LAMP_OFF;
					closed_lamp_n = LAMP_OFF;
				end
			end
			ACT_FINISH: begin
				if (req.sel) begin
					if (fault_q == FAULT_OK) begin
						on_n  = 1'b0;
						dir_n = 1'b0;
					end
					case (pos)
						POS_CLOSED: begin
							open_lamp_n   = LAMP_OFF;
							closed_lamp_n = LAMP_ON;
						end
						POS_OPEN: begin
							open_lamp_n   = LAMP_ON;
							closed_lamp_n = LAMP_OFF;
						end
						default: begin
							open_lamp_n   = LAMP_BLINK;
							closed_lamp_n = LAMP_BLINK;
						end
					endcase
				end
			end
			ACT_OVERLOAD: begin
				if (req.sel) begin
					if (fault_q == FAULT_OK) begin
						on_n  = 1'b0;
						dir_n = 1'b0;
					end
					fault_n       = FAULT_OVERLOAD;
					open_lamp_n   = LAMP_BLINK;
					closed_lamp_n = LAMP_BLINK;
				end
			end
			default: begin
			end
		endcase

		if (do_start && fault_n == FAULT_OK) begin
			on_n          = 1'b1;
			dir_n         = start_open ? req.open_level : ~req.open_level;
			open_lamp_n   = start_open ? LAMP_BLINK : LAMP_OFF;
			closed_lamp_n = start_open ? LAMP_OFF : LAMP_BLINK;
			cc_cnt_n      = TW'(current_check_ticks);
			cc_arm_n      = 1'b1;
			rl_cnt_n      = TW'(run_limit_ticks);
			rl_arm_n      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q          <= 1'b0;
			dir_q         <= 1'b0;
			fault_q       <= FAULT_OK;
			cc_arm_q      <= 1'b0;
			cc_cnt_q      <= '0;
			rl_arm_q      <= 1'b0;
			rl_cnt_q      <= '0;
			open_lamp_q   <= LAMP_BLINK;
			closed_lamp_q <= LAMP_BLINK;
		end else if (advance) begin
			on_q          <= on_n;
			dir_q         <= dir_n;
			fault_q       <= fault_n;
			cc_arm_q      <= cc_arm_n;
			cc_cnt_q      <= cc_cnt_n;
			rl_arm_q      <= rl_arm_n;
			rl_cnt_q      <= rl_cnt_n;
			open_lamp_q   <= open_lamp_n;
			closed_lamp_q <= closed_lamp_n;
		end
	end

	assign nxt = '{enable: on_n, direction: dir_n, fault: fault_n,
		open_lamp: open_lamp_n, closed_lamp: closed_lamp_n};

endmodule

@@ design/dual_valve_drive_supervisor.sv @@
// top level of the dual valve drive supervisor
// usage:
// requests enter on the s_ group: s_tuser carries the action and the valve select,
// s_tdata the position-check flag, the limit-switch pins and the current-sense pins.
// every request gives exactly one result on the m_ group: drive pins, fault codes,
// lamp modes and the report flag, all packed in m_tdata.
// a request is held in the input register; the cold and hot valve units then
// update their state and the result register in the same cycle.
// one request per cycle is sustained while the receiver takes results; the only loop is
// the state update of each valve unit.
// when the receiver stalls, the result register holds and the input register still
// takes one more request; s_tready then drops until the result is taken.
// reset (arst_n low) stops both drives, clears faults, timers and pending results,
// sets all lamps to blink and loads the register defaults; the user must write registers
// through cfg_wen/cfg_index/cfg_wdata only while the block is idle, not enforced here.
`include "dual_valve_drive_supervisor_assert.svh"

module dual_valve_drive_supervisor
	import dvds_pkg::*;
#(
	parameter int TICK_COUNT_WIDTH = TICK_COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// check_position, cold_open_pin, cold_closed_pin, hot_open_pin, hot_closed_pin,
	// cold_current, hot_current, zero pad
	input  logic [7:0]       s_tdata,
	// action[2:0], valve
	input  logic [3:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// cold_enable, cold_direction, hot_enable, hot_direction, cold_fault[1:0],
	// hot_fault[1:0], cold_open_lamp[1:0], cold_closed_lamp[1:0], hot_open_lamp[1:0],
	// hot_closed_lamp[1:0], report_request, zero pad
	output logic [23:0]      m_tdata,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0] cc_ticks_q, rl_ticks_q;
	logic             cold_level_q, hot_level_q;

	logic             valid_s1;
	action_t          act_s1;
	logic             valve_s1;
	logic [6:0]       pins_s1;

	logic             out_valid_q;
	logic [16:0]      out_data_q;

	logic             advance;
	valve_in_t        cold_req, hot_req;
	valve_out_t       cold_nxt, hot_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_ticks_q   <= CURRENT_CHECK_RESET;
			rl_ticks_q   <= RUN_LIMIT_RESET;
			cold_level_q <= COLD_LEVEL_RESET;
			hot_level_q  <= HOT_LEVEL_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CURRENT_CHECK: cc_ticks_q   <= cfg_wdata;
				CFG_RUN_LIMIT:     rl_ticks_q   <= cfg_wdata;
				CFG_COLD_LEVEL:    cold_level_q <= cfg_wdata[0];
				CFG_HOT_LEVEL:     hot_level_q  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1   <= action_t'(s_tuser[2:0]);
			valve_s1 <= s_tuser[3];
			pins_s1  <= s_tdata[6:0];
		end
	end

	assign cold_req = '{action: act_s1, sel: !valve_s1, check: pins_s1[0],
		open_pin: pins_s1[1], closed_pin: pins_s1[2], current: pins_s1[5],
		open_level: cold_level_q};
	assign hot_req = '{action: act_s1, sel: valve_s1, check: pins_s1[0],
		open_pin: pins_s1[3], closed_pin: pins_s1[4], current: pins_s1[6],
		open_level: hot_level_q};

	dvds_valve #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_cold (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.req                (cold_req),
		.current_check_ticks(cc_ticks_q),
		.run_limit_ticks    (rl_ticks_q),
		.nxt                (cold_nxt)
	);

	dvds_valve #(
		.TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
	) u_hot (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.req                (hot_req),
		.current_check_ticks(cc_ticks_q),
		.run_limit_ticks    (rl_ticks_q),
		.nxt                (hot_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_data_q <= {act_s1 == ACT_FINISH,
				hot_nxt.closed_lamp, hot_nxt.open_lamp,
				cold_nxt.closed_lamp, cold_nxt.open_lamp,
				hot_nxt.fault, cold_nxt.fault,
				hot_nxt.direction, hot_nxt.enable,
				cold_nxt.direction, cold_nxt.enable};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_data_q};

	`DVDS_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, m_tvalid)
	`DVDS_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, !s_tready,
		valid_s1 && m_tvalid && !m_tready)
	`DVDS_ASSERT_IMPLY(a_cold_dir_low_when_off, clk, arst_n, m_tvalid && !m_tdata[0],
		!m_tdata[1])
	`DVDS_ASSERT_IMPLY(a_hot_dir_low_when_off, clk, arst_n, m_tvalid && !m_tdata[2],
		!m_tdata[3])

endmodule
